[rtl/bnf_pkg.sv]
package bnf_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 256;
    localparam int CFG_W      = 25;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 24;
    localparam int ROOT_W     = 24;

    typedef logic [2:0] t_action;
    localparam t_action ACT_WRITE = 3'd0;
    localparam t_action ACT_ACCUM = 3'd1;
    localparam t_action ACT_FINAL = 3'd2;
    localparam t_action ACT_NORM  = 3'd3;
    localparam t_action ACT_READ  = 3'd4;

    typedef logic [1:0] t_word_sel;
    localparam t_word_sel SEL_GAMMA = 2'd0;
    localparam t_word_sel SEL_BETA  = 2'd1;
    localparam t_word_sel SEL_RMEAN = 2'd2;
    localparam t_word_sel SEL_RVAR  = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TRAINING = 3'd0;
    localparam t_cfg_idx CFG_AFFINE   = 3'd1;
    localparam t_cfg_idx CFG_EPSILON  = 3'd2;
    localparam t_cfg_idx CFG_MOMENTUM = 3'd3;
    localparam t_cfg_idx CFG_COUNT    = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_DISP, S_ACC,
        S_F_MEAN, S_F_E2, S_F_B1, S_F_B2, S_F_B3, S_F_B4, S_F_B5,
        S_F_SQ_GO, S_F_SQ_WAIT,
        S_N_DIV, S_N_AFF, S_N_FIN, S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } t_itu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_itu_sts;

    function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic [DATA_W-1:0] r;
        if (v > 64'sd2147483647) r = 32'h7FFF_FFFF;
        else if (v < -64'sd2147483648) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 32'd1) : v;
    endfunction

    // signed result of +-q for a 64-bit magnitude, saturated to a word
    function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                  input logic [63:0] q);
        logic [DATA_W-1:0] r;
        if (neg) r = (q[63:31] != 33'd0) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        else r = (q[63:31] != 33'd0) ? 32'h7FFF_FFFF : q[31:0];
        return r;
    endfunction

endpackage

[rtl/bnf_iter_unit.sv]
module bnf_iter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bnf_pkg::t_itu_ctl i_ctl,
    input  logic [63:0]       i_dividend,
    input  logic [31:0]       i_divisor,
    output bnf_pkg::t_itu_sts o_sts,
    output logic [63:0]       o_quotient,
    output logic [23:0]       o_root
);

    logic        r_busy, r_done, r_sqrt;
    logic [6:0]  r_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_acc;
    logic [23:0] r_root;
    logic [31:0] r_div;

    logic [33:0] w_shift, w_trial;
    logic [34:0] w_diff;
    logic        w_ge;

    // restoring step: one quotient bit, or one root bit from two radicand bits
    always_comb begin
        w_shift = r_sqrt ? {r_rem[31:0], r_acc[63:62]} : {r_rem[32:0], r_acc[63]};
        w_trial = r_sqrt ? {8'd0, r_root, 2'b01} : {2'd0, r_div};
        w_diff  = {1'b0, w_shift} - {1'b0, w_trial};
        w_ge    = ~w_diff[34];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.is_sqrt ? 7'(bnf_pkg::SQRT_STEPS - 1)
                                        : 7'(bnf_pkg::DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 7'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sqrt <= i_ctl.is_sqrt;
            r_rem  <= 34'd0;
            r_acc  <= i_dividend;
            r_root <= 24'd0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[33:0] : w_shift;
            if (r_sqrt) begin
                r_acc  <= {r_acc[61:0], 2'b00};
                r_root <= {r_root[22:0], w_ge};
            end else begin
                r_acc <= {r_acc[62:0], w_ge};
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_acc;
    assign o_root     = r_root;

endmodule

[rtl/batch_norm_forward_core.sv]
// Per-channel batch normalization, forward pass, signed Q16.16.
// Input channel (i_valid / o_ready) carries one item: action, channel,
// word select and value. Write word, accumulate and finalize give no result;
// normalize and read word give one item on the output channel
// (o_valid / i_ready): kind, out_value and pre_affine_value.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_wdata,
// by the user only while the block is idle; the block does not enforce it.
// One item is in flight at a time; o_ready is high only in the idle state.
// Normalize skips the divide when the channel std is zero; finalize runs
// the mean and mean-square divides and, with nonzero momentum, the running
// blend only in training, and the square root in every mode.
// The shared iterative unit takes 64 steps per divide (mean, mean square,
// normalize) and 24 steps per square root.
// The result sits in an output register; while the receiver stalls the
// next item is still taken, and its result waits until the register frees.
// Reset (synchronous, active low) loads the register defaults and marks all
// channel accumulators as zero; table words are undefined until written.
module batch_norm_forward_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_channel,
    input  logic [1:0]  i_word_select,
    input  logic [31:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [31:0] o_out_value,
    output logic [31:0] o_pre_affine_value,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [24:0] i_cfg_wdata
);

    localparam int NCH = bnf_pkg::NUM_CH;

    bnf_pkg::t_state r_state, n_state;

    logic        r_cfg_train, r_cfg_aff;
    logic [16:0] r_cfg_eps, r_cfg_mom;
    logic [24:0] r_cfg_cnt;

    logic [2:0]  r_act;
    logic [7:0]  r_ch;
    logic [1:0]  r_sel;
    logic [31:0] r_x;

    logic [31:0] m_gamma [NCH];
    logic [31:0] m_beta  [NCH];
    logic [31:0] m_rmean [NCH];
    logic [31:0] m_rvar  [NCH];
    logic [31:0] m_bmean [NCH];
    logic [31:0] m_std   [NCH];
    logic [63:0] m_sum   [NCH];
    logic [63:0] m_sq    [NCH];
    logic [NCH-1:0] r_acc_vld;

    logic [31:0] r_rd_gamma, r_rd_beta, r_rd_rmean, r_rd_rvar, r_rd_bmean, r_rd_std;
    logic [63:0] r_rd_sum, r_rd_sq;
    logic        r_rd_vld;

    logic [63:0]        r_prod;
    logic [31:0]        r_mean, r_var, r_o, r_res, r_pre;
    logic               r_neg, r_kind;
    logic signed [49:0] r_blend;

    logic        r_o_valid, r_o_kind;
    logic [31:0] r_o_out, r_o_pre;

    bnf_pkg::t_itu_ctl w_ctl;
    bnf_pkg::t_itu_sts w_sts;
    logic [63:0] w_dividend, w_quot;
    logic [31:0] w_divisor;
    logic [23:0] w_root;

    bnf_iter_unit u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_sts),
        .o_quotient (w_quot),
        .o_root     (w_root)
    );

    logic        w_accept, w_load;
    logic [63:0] w_sum, w_sq, w_sum_mag;
    logic [24:0] w_n;
    logic [16:0] w_mom, w_mom_c;
    logic [31:0] w_mean_sel, w_ma, w_mb, w_word;
    logic signed [32:0] w_diff;
    logic [32:0] w_dmag;
    logic        w_sd_bad;
    logic [47:0] w_msq;
    logic [63:0] w_e2d;
    logic [31:0] w_var;
    logic signed [49:0] w_bsum, w_bsh, w_bterm;
    logic [31:0] w_blend;
    logic        w_pneg;
    logic [47:0] w_pr;
    logic signed [49:0] w_aff;
    logic [64:0] w_sum_add, w_sq_add;
    logic [63:0] w_sum_new, w_sq_new;

    logic w_we_gamma, w_we_beta, w_we_rmean, w_we_rvar, w_we_fin, w_we_acc;
    logic [31:0] w_rmean_d, w_rvar_d;

    assign w_accept = i_valid && o_ready;
    assign w_load   = (r_state == bnf_pkg::S_OUT) && (!r_o_valid || i_ready);

    always_comb begin
        w_sum      = r_rd_vld ? r_rd_sum : 64'd0;
        w_sq       = r_rd_vld ? r_rd_sq : 64'd0;
        w_sum_mag  = w_sum[63] ? (~w_sum + 64'd1) : w_sum;
        w_n        = (r_cfg_cnt == 25'd0) ? 25'd1 : r_cfg_cnt;
        w_mom      = (r_cfg_mom > 17'd65536) ? 17'd65536 : r_cfg_mom;
        w_mom_c    = 17'd65536 - w_mom;
        w_mean_sel = r_cfg_train ? r_rd_bmean : r_rd_rmean;
        w_diff     = $signed({r_x[31], r_x}) - $signed({w_mean_sel[31], w_mean_sel});
        w_dmag     = w_diff[32] ? (~w_diff + 33'd1) : w_diff;
        w_sd_bad   = r_rd_std[31] || (r_rd_std == 32'd0);
        // variance: E[x^2] minus mean squared, clamped to [0, max word]
        w_msq      = r_prod[63:16];
        w_e2d      = w_quot - {16'd0, w_msq};
        if (w_quot <= {16'd0, w_msq}) w_var = 32'd0;
        else if (w_e2d[63:31] != 33'd0) w_var = 32'h7FFF_FFFF;
        else w_var = w_e2d[31:0];
        // blend: second product term, summed and floored by 2^16
        w_bterm    = r_mean[31] && (r_state == bnf_pkg::S_F_B3)
                     ? -$signed({1'b0, r_prod[48:0]}) : $signed({1'b0, r_prod[48:0]});
        w_bsum     = r_blend + w_bterm;
        w_bsh      = w_bsum >>> 16;
        w_blend    = bnf_pkg::sat32({{14{w_bsh[49]}}, w_bsh});
        // affine: floor(o * gamma / 2^16) + beta
        w_pneg     = r_o[31] ^ r_rd_gamma[31];
        w_pr       = r_prod[63:16] + {47'd0, (w_pneg && (r_prod[15:0] != 16'd0))};
        w_aff      = (w_pneg ? -$signed({2'b00, w_pr}) : $signed({2'b00, w_pr}))
                     + $signed({{18{r_rd_beta[31]}}, r_rd_beta});
        // accumulate with saturation
        w_sum_add  = {w_sum[63], w_sum} + {{33{r_x[31]}}, r_x};
        w_sum_new  = (w_sum_add[64] != w_sum_add[63])
                     ? (w_sum_add[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF)
                     : w_sum_add[63:0];
        w_sq_add   = {1'b0, w_sq} + {17'd0, r_prod[63:16]};
        w_sq_new   = w_sq_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : w_sq_add[63:0];
        case (r_sel)
            bnf_pkg::SEL_GAMMA: w_word = r_rd_gamma;
            bnf_pkg::SEL_BETA:  w_word = r_rd_beta;
            bnf_pkg::SEL_RMEAN: w_word = r_rd_rmean;
            default:            w_word = r_rd_rvar;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bnf_pkg::S_IDLE: if (i_valid) n_state = bnf_pkg::S_RD;
            bnf_pkg::S_RD:   n_state = bnf_pkg::S_DISP;
            bnf_pkg::S_DISP: begin
                case (r_act)
                    bnf_pkg::ACT_ACCUM: n_state = bnf_pkg::S_ACC;
                    bnf_pkg::ACT_FINAL: n_state = r_cfg_train ? bnf_pkg::S_F_MEAN
                                                              : bnf_pkg::S_F_SQ_GO;
                    bnf_pkg::ACT_NORM:  n_state = w_sd_bad ? bnf_pkg::S_N_AFF
                                                           : bnf_pkg::S_N_DIV;
                    bnf_pkg::ACT_READ:  n_state = bnf_pkg::S_OUT;
                    default:            n_state = bnf_pkg::S_IDLE;
                endcase
            end
            bnf_pkg::S_ACC:    n_state = bnf_pkg::S_IDLE;
            bnf_pkg::S_F_MEAN: if (w_sts.done) n_state = bnf_pkg::S_F_E2;
            bnf_pkg::S_F_E2: begin
                if (w_sts.done)
                    n_state = (w_mom == 17'd0) ? bnf_pkg::S_F_SQ_GO : bnf_pkg::S_F_B1;
            end
            bnf_pkg::S_F_B1:      n_state = bnf_pkg::S_F_B2;
            bnf_pkg::S_F_B2:      n_state = bnf_pkg::S_F_B3;
            bnf_pkg::S_F_B3:      n_state = bnf_pkg::S_F_B4;
            bnf_pkg::S_F_B4:      n_state = bnf_pkg::S_F_B5;
            bnf_pkg::S_F_B5:      n_state = bnf_pkg::S_F_SQ_GO;
            bnf_pkg::S_F_SQ_GO:   n_state = bnf_pkg::S_F_SQ_WAIT;
            bnf_pkg::S_F_SQ_WAIT: if (w_sts.done) n_state = bnf_pkg::S_IDLE;
            bnf_pkg::S_N_DIV:     if (w_sts.done) n_state = bnf_pkg::S_N_AFF;
            bnf_pkg::S_N_AFF:     n_state = bnf_pkg::S_N_FIN;
            bnf_pkg::S_N_FIN:     n_state = bnf_pkg::S_OUT;
            bnf_pkg::S_OUT:       if (w_load) n_state = bnf_pkg::S_IDLE;
            default:              n_state = bnf_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: shared unit, multiplier operands, table writes
    always_comb begin
        w_ctl      = '0;
        w_divisor  = {7'd0, w_n};
        w_ma       = 32'd0;
        w_mb       = 32'd0;
        w_we_gamma = 1'b0;
        w_we_beta  = 1'b0;
        w_we_rmean = 1'b0;
        w_we_rvar  = 1'b0;
        w_we_fin   = 1'b0;
        w_we_acc   = 1'b0;
        w_rmean_d  = r_x;
        w_rvar_d   = r_x;
        w_dividend = w_sum_mag;
        unique case (r_state)
            bnf_pkg::S_DISP: begin
                w_ma = bnf_pkg::mag32(r_x);
                w_mb = bnf_pkg::mag32(r_x);
                if (r_act == bnf_pkg::ACT_WRITE) begin
                    w_we_gamma = (r_sel == bnf_pkg::SEL_GAMMA);
                    w_we_beta  = (r_sel == bnf_pkg::SEL_BETA);
                    w_we_rmean = (r_sel == bnf_pkg::SEL_RMEAN);
                    w_we_rvar  = (r_sel == bnf_pkg::SEL_RVAR);
                end
                if (r_act == bnf_pkg::ACT_FINAL && r_cfg_train) w_ctl.start = 1'b1;
                if (r_act == bnf_pkg::ACT_NORM && !w_sd_bad) begin
                    w_ctl.start = 1'b1;
                    w_dividend  = {15'd0, w_dmag, 16'd0};
                    w_divisor   = r_rd_std;
                end
            end
            bnf_pkg::S_ACC: w_we_acc = 1'b1;
            bnf_pkg::S_F_MEAN: begin
                w_ctl.start = w_sts.done;
                w_dividend  = w_sq;
            end
            bnf_pkg::S_F_E2: begin
                w_ma = bnf_pkg::mag32(r_mean);
                w_mb = bnf_pkg::mag32(r_mean);
            end
            bnf_pkg::S_F_B1: begin
                w_ma = bnf_pkg::mag32(r_rd_rmean);
                w_mb = {15'd0, w_mom};
            end
            bnf_pkg::S_F_B2: begin
                w_ma = bnf_pkg::mag32(r_mean);
                w_mb = {15'd0, w_mom_c};
            end
            bnf_pkg::S_F_B3: begin
                w_ma       = bnf_pkg::mag32(r_rd_rvar);
                w_mb       = {15'd0, w_mom};
                w_we_rmean = 1'b1;
                w_rmean_d  = w_blend;
            end
            bnf_pkg::S_F_B4: begin
                w_ma = r_var;
                w_mb = {15'd0, w_mom_c};
            end
            bnf_pkg::S_F_B5: begin
                w_we_rvar = 1'b1;
                w_rvar_d  = w_blend;
            end
            bnf_pkg::S_F_SQ_GO: begin
                w_ctl.start   = 1'b1;
                w_ctl.is_sqrt = 1'b1;
                w_dividend    = {r_var + {15'd0, r_cfg_eps}, 32'd0};
            end
            bnf_pkg::S_F_SQ_WAIT: w_we_fin = w_sts.done;
            bnf_pkg::S_N_AFF: begin
                w_ma = bnf_pkg::mag32(r_o);
                w_mb = bnf_pkg::mag32(r_rd_gamma);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bnf_pkg::S_IDLE;
            r_cfg_train <= 1'b1;
            r_cfg_aff   <= 1'b1;
            r_cfg_eps   <= 17'd1;
            r_cfg_mom   <= 17'd58982;
            r_cfg_cnt   <= 25'd1;
            r_acc_vld   <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bnf_pkg::CFG_TRAINING: r_cfg_train <= i_cfg_wdata[0];
                    bnf_pkg::CFG_AFFINE:   r_cfg_aff   <= i_cfg_wdata[0];
                    bnf_pkg::CFG_EPSILON:  r_cfg_eps   <= i_cfg_wdata[16:0];
                    bnf_pkg::CFG_MOMENTUM: r_cfg_mom   <= i_cfg_wdata[16:0];
                    bnf_pkg::CFG_COUNT:    r_cfg_cnt   <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (w_we_acc) r_acc_vld[r_ch] <= 1'b1;
            else if (w_we_fin) r_acc_vld[r_ch] <= 1'b0;
            if (w_load) r_o_valid <= 1'b1;
            else if (i_ready) r_o_valid <= 1'b0;
        end
    end

    // tables
    always_ff @(posedge i_clk) begin
        if (w_we_gamma) m_gamma[r_ch] <= r_x;
        if (w_we_beta)  m_beta[r_ch]  <= r_x;
        if (w_we_rmean) m_rmean[r_ch] <= w_rmean_d;
        if (w_we_rvar)  m_rvar[r_ch]  <= w_rvar_d;
        if (w_we_fin) begin
            m_std[r_ch] <= {8'd0, w_root};
            if (r_cfg_train) m_bmean[r_ch] <= r_mean;
        end
        if (w_we_acc) begin
            m_sum[r_ch] <= w_sum_new;
            m_sq[r_ch]  <= w_sq_new;
        end
        r_rd_gamma <= m_gamma[r_ch];
        r_rd_beta  <= m_beta[r_ch];
        r_rd_rmean <= m_rmean[r_ch];
        r_rd_rvar  <= m_rvar[r_ch];
        r_rd_bmean <= m_bmean[r_ch];
        r_rd_std   <= m_std[r_ch];
        r_rd_sum   <= m_sum[r_ch];
        r_rd_sq    <= m_sq[r_ch];
        r_rd_vld   <= r_acc_vld[r_ch];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, w_ma} * {32'd0, w_mb};
        case (r_state)
            bnf_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_act <= i_action;
                    r_ch  <= i_channel;
                    r_sel <= i_word_select;
                    r_x   <= i_value;
                end
            end
            bnf_pkg::S_DISP: begin
                r_var  <= r_rd_rvar[31] ? 32'd0 : r_rd_rvar;
                r_neg  <= w_diff[32];
                r_o    <= (w_diff == 33'sd0) ? 32'd0
                          : (w_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
                r_kind <= 1'b1;
                r_res  <= w_word;
                r_pre  <= 32'd0;
            end
            bnf_pkg::S_F_MEAN: if (w_sts.done) r_mean <= bnf_pkg::sat_mag(w_sum[63], w_quot);
            bnf_pkg::S_F_E2:   if (w_sts.done) r_var <= w_var;
            bnf_pkg::S_F_B2:   r_blend <= r_rd_rmean[31] ? -$signed({1'b0, r_prod[48:0]})
                                                        : $signed({1'b0, r_prod[48:0]});
            bnf_pkg::S_F_B4:   r_blend <= r_rd_rvar[31] ? -$signed({1'b0, r_prod[48:0]})
                                                       : $signed({1'b0, r_prod[48:0]});
            bnf_pkg::S_N_DIV:  if (w_sts.done) r_o <= bnf_pkg::sat_mag(r_neg, w_quot);
            bnf_pkg::S_N_FIN: begin
                r_kind <= 1'b0;
                r_pre  <= r_o;
                r_res  <= r_cfg_aff ? bnf_pkg::sat32({{14{w_aff[49]}}, w_aff}) : r_o;
            end
            default: ;
        endcase
        if (w_load) begin
            r_o_kind <= r_kind;
            r_o_out  <= r_res;
            r_o_pre  <= r_pre;
        end
    end

    assign o_ready            = (r_state == bnf_pkg::S_IDLE);
    assign o_valid            = r_o_valid;
    assign o_kind             = r_o_kind;
    assign o_out_value        = r_o_out;
    assign o_pre_affine_value = r_o_pre;

    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.start |-> !w_sts.busy)
        else $error("shared unit started while busy");

    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == bnf_pkg::S_F_MEAN || r_state == bnf_pkg::S_F_E2 ||
                        r_state == bnf_pkg::S_F_SQ_WAIT || r_state == bnf_pkg::S_N_DIV))
        else $error("shared unit finished with nobody waiting");

    a_rose_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == bnf_pkg::S_OUT))
        else $error("result shown outside the result state");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bnf_pkg::S_OUT && r_o_valid && !i_ready) |=> (r_state == bnf_pkg::S_OUT))
        else $error("pending result overwritten");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam longint DMAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint DMIN   = -DMAX - 1;
    localparam longint I64MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64MIN = -I64MAX - 1;
    localparam longint unsigned WIDE = 64'd1 << 61;
    localparam int QUIET_CYCLES = 300;

    typedef struct {
        logic        kind;
        logic [31:0] out_value;
        logic [31:0] pre_value;
    } t_norm_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    bnf_pkg::t_action    i_action = bnf_pkg::ACT_WRITE;
    logic [7:0]          i_channel = '0;
    bnf_pkg::t_word_sel  i_word_select = bnf_pkg::SEL_GAMMA;
    logic [31:0]         i_value = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_kind;
    logic [31:0]         o_out_value;
    logic [31:0]         o_pre_affine_value;
    logic                i_cfg_we = 1'b0;
    bnf_pkg::t_cfg_idx   i_cfg_addr = bnf_pkg::CFG_TRAINING;
    logic [24:0]         i_cfg_wdata = '0;

    batch_norm_forward_core DUT (.*);

    always #1 i_clk = ~i_clk;

    // mirror of the block's state and registers
    logic        bn_training, bn_affine;
    logic [16:0] bn_epsilon, bn_momentum;
    logic [24:0] bn_count;
    longint          acc_sum[bnf_pkg::NUM_CH];
    longint unsigned acc_sq[bnf_pkg::NUM_CH];
    longint          word_tab[4][bnf_pkg::NUM_CH];
    longint          batch_mean[bnf_pkg::NUM_CH], chan_std[bnf_pkg::NUM_CH];
    bit              word_ok[4][bnf_pkg::NUM_CH];
    bit              mean_ok[bnf_pkg::NUM_CH], std_ok[bnf_pkg::NUM_CH];

    t_norm_result pending[$];
    int sent_items = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_start = 1'b0;
    bit hold_on = 1'b0;

    function automatic longint sat_word(longint v);
        return v > DMAX ? DMAX : (v < DMIN ? DMIN : v);
    endfunction

    function automatic longint unsigned mag(longint v);
        return v < 0 ? 64'd0 - longint'(unsigned'(v)) : unsigned'(v);
    endfunction

    function automatic longint from_mag(bit neg, longint unsigned m);
        if (m > WIDE) m = WIDE;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint floor_shift(bit neg, longint unsigned m, int sh);
        longint unsigned r;
        r = m >> sh;
        if (neg && (m & ((64'd1 << sh) - 1)) != 0) r++;
        return from_mag(neg, r);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint std_from_var(longint unsigned var_q);
        longint unsigned v, lim;
        lim = 64'hFFFF_FFFF_FFFF_FFFF >> 16;
        v = var_q + bn_epsilon;
        if (v > lim) v = lim;
        return sat_word(longint'(int_sqrt(v << 16)));
    endfunction

    function automatic longint blend(longint run, longint batch, longint unsigned m);
        longint a, b, s;
        a = from_mag(run < 0, mag(run) * m);
        b = from_mag(batch < 0, mag(batch) * (64'd65536 - m));
        s = a + b;
        return sat_word(floor_shift(s < 0, mag(s), 16));
    endfunction

    function automatic bit item_allowed(bnf_pkg::t_action a, int c, bnf_pkg::t_word_sel s);
        bit ok;
        ok = 1'b1;
        case (a)
            bnf_pkg::ACT_FINAL:
                if (bn_training)
                    ok = bn_momentum == 0 || (word_ok[bnf_pkg::SEL_RMEAN][c] &&
                                              word_ok[bnf_pkg::SEL_RVAR][c]);
                else
                    ok = word_ok[bnf_pkg::SEL_RVAR][c];
            bnf_pkg::ACT_NORM: begin
                ok = std_ok[c] && (bn_training ? mean_ok[c] : word_ok[bnf_pkg::SEL_RMEAN][c]);
                if (bn_affine)
                    ok = ok && word_ok[bnf_pkg::SEL_GAMMA][c] && word_ok[bnf_pkg::SEL_BETA][c];
            end
            bnf_pkg::ACT_READ: ok = word_ok[s][c];
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    task automatic finalize_channel(int c);
        longint unsigned n, e2, mm, msq, var_q, m;
        longint s, mean, rv;
        n = (bn_count != 0) ? bn_count : 1;
        if (bn_training) begin
            s = acc_sum[c];
            mean = sat_word(from_mag(s < 0, mag(s) / n));
            e2 = acc_sq[c] / n;
            mm = mag(mean);
            msq = (mm * mm) >> 16;
            var_q = (e2 > msq) ? e2 - msq : 0;
            m = (bn_momentum > 65536) ? 65536 : bn_momentum;
            if (var_q > DMAX) var_q = DMAX;
            batch_mean[c] = mean;
            mean_ok[c] = 1'b1;
            if (m != 0) begin
                word_tab[bnf_pkg::SEL_RMEAN][c] = blend(word_tab[bnf_pkg::SEL_RMEAN][c], mean, m);
                word_tab[bnf_pkg::SEL_RVAR][c] = blend(word_tab[bnf_pkg::SEL_RVAR][c],
                                                       longint'(var_q), m);
            end
            chan_std[c] = std_from_var(var_q);
        end else begin
            rv = word_tab[bnf_pkg::SEL_RVAR][c];
            chan_std[c] = std_from_var(rv < 0 ? 0 : rv);
        end
        std_ok[c] = 1'b1;
        acc_sum[c] = 0;
        acc_sq[c] = 0;
    endtask

    task automatic predict_item(bnf_pkg::t_action a, int c, bnf_pkg::t_word_sel s,
                                logic [31:0] v);
        longint x, mean, diff, sd, o, res, g, p;
        longint unsigned sq;
        t_norm_result r;
        x = longint'($signed(v));
        case (a)
            bnf_pkg::ACT_WRITE: begin
                word_tab[s][c] = x;
                word_ok[s][c] = 1'b1;
            end
            bnf_pkg::ACT_ACCUM: begin
                sq = (mag(x) * mag(x)) >> 16;
                if (x > 0 && acc_sum[c] > I64MAX - x) acc_sum[c] = I64MAX;
                else if (x < 0 && acc_sum[c] < I64MIN - x) acc_sum[c] = I64MIN;
                else acc_sum[c] += x;
                acc_sq[c] = (acc_sq[c] > 64'hFFFF_FFFF_FFFF_FFFF - sq) ?
                            64'hFFFF_FFFF_FFFF_FFFF : acc_sq[c] + sq;
            end
            bnf_pkg::ACT_FINAL: finalize_channel(c);
            bnf_pkg::ACT_NORM: begin
                mean = bn_training ? batch_mean[c] : word_tab[bnf_pkg::SEL_RMEAN][c];
                diff = x - mean;
                sd = chan_std[c];
                if (sd <= 0)
                    o = (diff == 0) ? 0 : (diff < 0 ? DMIN : DMAX);
                else
                    o = sat_word(from_mag(diff < 0, (mag(diff) << 16) / longint'(sd)));
                res = o;
                if (bn_affine) begin
                    g = word_tab[bnf_pkg::SEL_GAMMA][c];
                    p = floor_shift((o < 0) != (g < 0), mag(o) * mag(g), 16);
                    res = sat_word(p + word_tab[bnf_pkg::SEL_BETA][c]);
                end
                r.kind = 1'b0;
                r.out_value = res[31:0];
                r.pre_value = o[31:0];
                pending.push_back(r);
            end
            bnf_pkg::ACT_READ: begin
                r.kind = 1'b1;
                r.out_value = word_tab[s][c][31:0];
                r.pre_value = '0;
                pending.push_back(r);
            end
            default: ;
        endcase
    endtask

    // items that would read an unwritten table entry are dropped here
    task automatic send_item(bnf_pkg::t_action a, logic [7:0] c, bnf_pkg::t_word_sel s,
                             logic [31:0] v);
        if (item_allowed(a, c, s)) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_action <= a;
            i_channel <= c;
            i_word_select <= s;
            i_value <= v;
            do @(posedge i_clk); while (!o_ready);
            predict_item(a, c, s, v);
            sent_items++;
        end
    endtask

    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(bit tr, bit af, int ep, int mo, int cn);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= bnf_pkg::CFG_TRAINING; i_cfg_wdata <= 25'(tr); @(posedge i_clk);
        i_cfg_addr <= bnf_pkg::CFG_AFFINE;   i_cfg_wdata <= 25'(af); @(posedge i_clk);
        i_cfg_addr <= bnf_pkg::CFG_EPSILON;  i_cfg_wdata <= 25'(ep); @(posedge i_clk);
        i_cfg_addr <= bnf_pkg::CFG_MOMENTUM; i_cfg_wdata <= 25'(mo); @(posedge i_clk);
        i_cfg_addr <= bnf_pkg::CFG_COUNT;    i_cfg_wdata <= 25'(cn); @(posedge i_clk);
        i_cfg_we <= 1'b0;
        bn_training = tr;
        bn_affine = af;
        bn_epsilon = 17'(ep);
        bn_momentum = 17'(mo);
        bn_count = 25'(cn);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(9))
            0, 1, 2: w = $urandom;
            3, 4, 5, 6: w = 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
            7: case ($urandom_range(3))
                   0: w = 32'h7FFF_FFFF;
                   1: w = 32'h8000_0000;
                   2: w = 32'hFFFF_FFFF;
                   default: w = 32'h0;
               endcase
            default: w = 32'h0001_0000 + $urandom_range(32'h8000) - 32'h4000;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] pick_channel();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
    endfunction

    // load words if needed or at random, accumulate a batch, finalize, then normalize and read back
    task automatic run_batch();
        logic [7:0] c;
        int k;
        c = pick_channel();
        if ($urandom_range(2) == 0 || !word_ok[bnf_pkg::SEL_RVAR][c]) begin
            send_item(bnf_pkg::ACT_WRITE, c, bnf_pkg::SEL_GAMMA, rand_word());
            send_item(bnf_pkg::ACT_WRITE, c, bnf_pkg::SEL_BETA, rand_word());
            send_item(bnf_pkg::ACT_WRITE, c, bnf_pkg::SEL_RMEAN, rand_word());
            send_item(bnf_pkg::ACT_WRITE, c, bnf_pkg::SEL_RVAR, rand_word());
        end
        k = $urandom_range(6);
        repeat (k) send_item(bnf_pkg::ACT_ACCUM, c, bnf_pkg::SEL_GAMMA, rand_word());
        send_item(bnf_pkg::ACT_FINAL, c, bnf_pkg::t_word_sel'($urandom_range(3)), rand_word());
        repeat ($urandom_range(1, 4))
            send_item(bnf_pkg::ACT_NORM, c, bnf_pkg::SEL_GAMMA, rand_word());
        send_item(bnf_pkg::ACT_READ, c, bnf_pkg::t_word_sel'($urandom_range(3)), $urandom);
    endtask

    task automatic run_random(int upto);
        while (sent_items < upto) begin
            if ($urandom_range(9) < 6)
                run_batch();
            else
                send_item(bnf_pkg::t_action'($urandom_range(7)), pick_channel(),
                          bnf_pkg::t_word_sel'($urandom_range(3)), rand_word());
        end
    endtask

    task automatic test_directed();
        bnf_pkg::t_action a;
        send_item(bnf_pkg::ACT_WRITE, 8'd0, bnf_pkg::SEL_GAMMA, 32'h7FFF_FFFF);
        send_item(bnf_pkg::ACT_WRITE, 8'd0, bnf_pkg::SEL_BETA, 32'h8000_0000);
        send_item(bnf_pkg::ACT_WRITE, 8'd0, bnf_pkg::SEL_RMEAN, 32'h8000_0000);
        send_item(bnf_pkg::ACT_WRITE, 8'd0, bnf_pkg::SEL_RVAR, 32'h7FFF_FFFF);
        for (int s = 0; s < 4; s++)
            send_item(bnf_pkg::ACT_READ, 8'd0, bnf_pkg::t_word_sel'(s), 32'h0);
        send_item(bnf_pkg::ACT_ACCUM, 8'd0, bnf_pkg::SEL_GAMMA, 32'h7FFF_FFFF);
        send_item(bnf_pkg::ACT_ACCUM, 8'd0, bnf_pkg::SEL_GAMMA, 32'h8000_0000);
        send_item(bnf_pkg::ACT_FINAL, 8'd0, bnf_pkg::SEL_GAMMA, 32'h0);
        send_item(bnf_pkg::ACT_NORM, 8'd0, bnf_pkg::SEL_GAMMA, 32'h7FFF_FFFF);
        send_item(bnf_pkg::ACT_NORM, 8'd0, bnf_pkg::SEL_GAMMA, 32'h8000_0000);
        send_item(bnf_pkg::ACT_NORM, 8'd0, bnf_pkg::SEL_GAMMA, 32'h0);
        // unused actions: no result
        for (int i = 5; i < 8; i++) begin
            a = bnf_pkg::t_action'(i);
            send_item(a, 8'd255, bnf_pkg::SEL_RVAR, 32'hFFFF_FFFF);
        end
        send_item(bnf_pkg::ACT_WRITE, 8'd255, bnf_pkg::SEL_GAMMA, 32'h8000_0000);
        send_item(bnf_pkg::ACT_WRITE, 8'd255, bnf_pkg::SEL_BETA, 32'h7FFF_FFFF);
        send_item(bnf_pkg::ACT_WRITE, 8'd255, bnf_pkg::SEL_RMEAN, 32'h0000_0003);
        send_item(bnf_pkg::ACT_WRITE, 8'd255, bnf_pkg::SEL_RVAR, 32'hFFFF_FFFB);
        send_item(bnf_pkg::ACT_FINAL, 8'd255, bnf_pkg::SEL_GAMMA, 32'h0);
        send_item(bnf_pkg::ACT_NORM, 8'd255, bnf_pkg::SEL_GAMMA, 32'h0001_0000);
        send_item(bnf_pkg::ACT_READ, 8'd255, bnf_pkg::SEL_RVAR, 32'h0);
        wait_quiet();
        // inference with a negative running variance, then zero std
        set_config(1'b0, 1'b1, 0, 0, 1);
        send_item(bnf_pkg::ACT_FINAL, 8'd255, bnf_pkg::SEL_GAMMA, 32'h0);
        send_item(bnf_pkg::ACT_NORM, 8'd255, bnf_pkg::SEL_GAMMA, 32'h0000_0003);
        send_item(bnf_pkg::ACT_NORM, 8'd255, bnf_pkg::SEL_GAMMA, 32'h0000_0004);
        send_item(bnf_pkg::ACT_NORM, 8'd255, bnf_pkg::SEL_GAMMA, 32'h8000_0000);
        wait_quiet();
    endtask

    task automatic test_config_sweep();
        int tr[7] = '{1, 1, 0, 0, 1, 1, 1};
        int af[7] = '{1, 0, 1, 0, 1, 1, 0};
        int ep[7] = '{1, 0, 65536, 0, 65536, 0, 12345};
        int mo[7] = '{58982, 0, 65536, 131071, 131071, 65536, 100};
        int cn[7] = '{4, 1, 2, 0, 16777216, 3, 6};
        for (int p = 0; p < 7; p++) begin
            set_config(tr[p], af[p], ep[p], mo[p], cn[p]);
            set_idling(p);
            run_random(sent_items + 110);
            wait_quiet();
        end
    endtask

    task automatic test_backpressure();
        set_idling(0);
        hold_start = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_item(bnf_pkg::ACT_READ, 8'd0, bnf_pkg::t_word_sel'(i % 4), 32'h0);
            send_item(bnf_pkg::ACT_NORM, 8'd0, bnf_pkg::SEL_GAMMA, rand_word());
        end
        wait_quiet();
    endtask

    task automatic test_random();
        int phase;
        phase = 0;
        while (sent_items < 1600) begin
            set_config($urandom_range(1), $urandom_range(1), $urandom_range(65536),
                       ($urandom_range(3) == 0) ? 0 : $urandom_range(65536),
                       $urandom_range(1, 8));
            set_idling(phase);
            run_random(sent_items + 100);
            wait_quiet();
            phase++;
        end
    endtask

    // long receiver hold so the output register fills and the input stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_on = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_on = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_norm_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: kind %0d out %h pre %h",
                             o_kind, o_out_value, o_pre_affine_value);
            end else begin
                e = pending.pop_front();
                if (o_kind !== e.kind || o_out_value !== e.out_value ||
                    o_pre_affine_value !== e.pre_value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d out %h pre %h, got kind %0d out %h pre %h",
                                 e.kind, e.out_value, e.pre_value,
                                 o_kind, o_out_value, o_pre_affine_value);
                end
            end
        end
        i_ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        bn_training = 1'b1;
        bn_affine = 1'b1;
        bn_epsilon = 17'd1;
        bn_momentum = 17'd58982;
        bn_count = 25'd1;
        for (int c = 0; c < bnf_pkg::NUM_CH; c++) begin
            acc_sum[c] = 0;
            acc_sq[c] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();
        wait_quiet();
        if (mismatches == 0 && pending.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
